### hw/rtl/lmtf_pkg.sv
package lmtf_pkg;

    localparam int NumMatrices = 4;
    localparam int NCols       = 8 * NumMatrices;
    localparam int ColW        = $clog2(NCols);

    typedef enum logic [2:0] {
        CMD_WR_COL  = 3'd0,
        CMD_WR_PIX  = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_CHAR    = 3'd3,
        CMD_REFRESH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ROWS
    } t_state;

    localparam logic [7:0] FirstCode    = 8'd29;
    localparam logic [7:0] LastCode     = 8'd126;
    localparam logic [7:0] FallbackCode = 8'd63;

    // one decoded command, as queued between front and back
    typedef struct packed {
        logic               is_walk;    // column walk (column/pixel write, clear, char)
        logic               is_pixel;
        logic               is_char;
        logic               is_refresh;
        logic signed [9:0]  start;      // first column of the walk
        logic signed [9:0]  glyph_end;  // columns below this take glyph bytes
        logic signed [9:0]  stop;       // exclusive end of walk
        logic [2:0]         pixel_row;
        logic [7:0]         value;
        logic [6:0]         font_idx;
        logic [2:0]         width;
        logic signed [8:0]  next_col;
    } t_op;

    localparam logic [2:0] WirePerm [8] = '{3'd4, 3'd5, 3'd1, 3'd6, 3'd2, 3'd0, 3'd7, 3'd3};
    localparam logic [2:0] ScanRows [8] = '{3'd3, 3'd1, 3'd7, 3'd0, 3'd2, 3'd5, 3'd4, 3'd6};

    // glyph: width in [42:40], column i in [8i+7:8i]
    function automatic logic [42:0] font_entry(input logic [6:0] idx);
        logic [42:0] e;
        case (idx)
            7'd0:  e = {3'd4, 40'h00_78_55_55_20};
            7'd1:  e = {3'd4, 40'h00_38_45_45_38};
            7'd2:  e = {3'd4, 40'h00_7C_41_41_3C};
            7'd3:  e = {3'd3, 40'h00_00_00_00_00};
            7'd4:  e = {3'd1, 40'h00_00_00_00_5F};
            7'd5:  e = {3'd3, 40'h00_00_03_00_03};
            7'd6:  e = {3'd5, 40'h14_3E_14_3E_14};
            7'd7:  e = {3'd4, 40'h00_12_2B_6A_24};
            7'd8:  e = {3'd5, 40'h63_64_08_13_63};
            7'd9:  e = {3'd5, 40'h50_20_56_49_36};
            7'd10: e = {3'd1, 40'h00_00_00_00_03};
            7'd11: e = {3'd3, 40'h00_00_41_22_1C};
            7'd12: e = {3'd3, 40'h00_00_1C_22_41};
            7'd13: e = {3'd5, 40'h28_18_0E_18_28};
            7'd14: e = {3'd5, 40'h08_08_3E_08_08};
            7'd15: e = {3'd2, 40'h00_00_00_70_B0};
            7'd16: e = {3'd3, 40'h00_00_08_08_08};
            7'd17: e = {3'd2, 40'h00_00_00_60_60};
            7'd18: e = {3'd4, 40'h00_01_06_18_60};
            7'd19: e = {3'd4, 40'h00_3E_41_41_3E};
            7'd20: e = {3'd3, 40'h00_00_40_7F_42};
            7'd21: e = {3'd4, 40'h00_46_49_51_62};
            7'd22: e = {3'd4, 40'h00_36_49_41_22};
            7'd23: e = {3'd4, 40'h00_7F_12_14_18};
            7'd24: e = {3'd4, 40'h00_39_45_45_27};
            7'd25: e = {3'd4, 40'h00_30_49_49_3E};
            7'd26: e = {3'd4, 40'h00_07_09_11_61};
            7'd27: e = {3'd4, 40'h00_36_49_49_36};
            7'd28: e = {3'd4, 40'h00_3E_49_49_06};
            7'd29: e = {3'd2, 40'h00_00_00_00_28};
            7'd30: e = {3'd2, 40'h00_00_00_50_80};
            7'd31: e = {3'd3, 40'h00_00_44_28_10};
            7'd32: e = {3'd3, 40'h00_00_14_14_14};
            7'd33: e = {3'd3, 40'h00_00_10_28_44};
            7'd34: e = {3'd4, 40'h00_06_09_59_02};
            7'd35: e = {3'd5, 40'h0E_5D_55_49_3E};
            7'd36: e = {3'd4, 40'h00_7E_11_11_7E};
            7'd37: e = {3'd4, 40'h00_36_49_49_7F};
            7'd38: e = {3'd4, 40'h00_22_41_41_3E};
            7'd39: e = {3'd4, 40'h00_3E_41_41_7F};
            7'd40: e = {3'd4, 40'h00_41_49_49_7F};
            7'd41: e = {3'd4, 40'h00_01_09_09_7F};
            7'd42: e = {3'd4, 40'h00_7A_49_41_3E};
            7'd43: e = {3'd4, 40'h00_7F_08_08_7F};
            7'd44: e = {3'd3, 40'h00_00_41_7F_41};
            7'd45: e = {3'd4, 40'h00_3F_41_40_30};
            7'd46: e = {3'd4, 40'h00_63_14_08_7F};
            7'd47: e = {3'd4, 40'h00_40_40_40_7F};
            7'd48: e = {3'd5, 40'h7F_02_0C_02_7F};
            7'd49: e = {3'd5, 40'h7F_10_08_04_7F};
            7'd50: e = {3'd4, 40'h00_3E_41_41_3E};
            7'd51: e = {3'd4, 40'h00_06_09_09_7F};
            7'd52: e = {3'd4, 40'h00_BE_41_41_3E};
            7'd53: e = {3'd4, 40'h00_76_09_09_7F};
            7'd54: e = {3'd4, 40'h00_32_49_49_46};
            7'd55: e = {3'd5, 40'h01_01_7F_01_01};
            7'd56: e = {3'd4, 40'h00_3F_40_40_3F};
            7'd57: e = {3'd5, 40'h0F_30_40_30_0F};
            7'd58: e = {3'd5, 40'h3F_40_38_40_3F};
            7'd59: e = {3'd5, 40'h63_14_08_14_63};
            7'd60: e = {3'd5, 40'h07_08_70_08_07};
            7'd61: e = {3'd4, 40'h00_47_49_51_61};
            7'd62: e = {3'd2, 40'h00_00_00_41_7F};
            7'd63: e = {3'd4, 40'h00_60_18_06_01};
            7'd64: e = {3'd2, 40'h00_00_00_7F_41};
            7'd65: e = {3'd3, 40'h00_00_02_01_02};
            7'd66: e = {3'd4, 40'h00_40_40_40_40};
            7'd67: e = {3'd2, 40'h00_00_00_02_01};
            7'd68: e = {3'd4, 40'h00_78_54_54_20};
            7'd69: e = {3'd4, 40'h00_38_44_44_7F};
            7'd70: e = {3'd4, 40'h00_28_44_44_38};
            7'd71: e = {3'd4, 40'h00_7F_44_44_38};
            7'd72: e = {3'd4, 40'h00_18_54_54_38};
            7'd73: e = {3'd3, 40'h00_00_05_7E_04};
            7'd74: e = {3'd4, 40'h00_78_A4_A4_98};
            7'd75: e = {3'd4, 40'h00_78_04_04_7F};
            7'd76: e = {3'd3, 40'h00_00_40_7D_44};
            7'd77: e = {3'd4, 40'h00_7D_84_80_40};
            7'd78: e = {3'd4, 40'h00_44_28_10_7F};
            7'd79: e = {3'd3, 40'h00_00_40_7F_41};
            7'd80: e = {3'd5, 40'h78_04_7C_04_7C};
            7'd81: e = {3'd4, 40'h00_78_04_04_7C};
            7'd82: e = {3'd4, 40'h00_38_44_44_38};
            7'd83: e = {3'd4, 40'h00_18_24_24_FC};
            7'd84: e = {3'd4, 40'h00_FC_24_24_18};
            7'd85: e = {3'd4, 40'h00_04_04_08_7C};
            7'd86: e = {3'd4, 40'h00_24_54_54_48};
            7'd87: e = {3'd3, 40'h00_00_44_3F_04};
            7'd88: e = {3'd4, 40'h00_7C_40_40_3C};
            7'd89: e = {3'd5, 40'h1C_20_40_20_1C};
            7'd90: e = {3'd5, 40'h3C_40_3C_40_3C};
            7'd91: e = {3'd5, 40'h44_28_10_28_44};
            7'd92: e = {3'd4, 40'h00_7C_A0_A0_9C};
            7'd93: e = {3'd3, 40'h00_00_4C_54_64};
            7'd94: e = {3'd3, 40'h00_00_41_36_08};
            7'd95: e = {3'd1, 40'h00_00_00_00_7F};
            7'd96: e = {3'd3, 40'h00_00_08_36_41};
            7'd97: e = {3'd4, 40'h00_04_08_04_08};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

### hw/rtl/led_matrix_text_framebuffer_unit.sv
// Channel  | dir | contents
// s_axis   | in  | tdata: cmd[2:0] column[10:3] end_column[18:11] pixel_row[21:19]
//          |     |        value[29:22] char_code[37:30] spacing[41:38], zero to 48
// m_axis   | out | tdata: row_drive[7:0] shift_bits[39:8] glyph_width[42:40]
//          |     |        next_column[51:43], zero to 56; tlast: last
// apb      | cfg | reg 0 at 0x0: flip
// A front decoder queues up to two ops; the back walks one column a cycle.
// Refresh emits one row a cycle from the buffer registers; output stall holds it.
// Reset (synchronous, low) clears the buffer and flip at once; no clearing pass.
module led_matrix_text_framebuffer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd, column, end_column, pixel_row, value, char_code, spacing
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // row_drive, shift_bits, glyph_width, next_column
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic          r_flip;
    logic          q_valid, q_ready;
    lmtf_pkg::t_op q_op;
    logic [7:0]    rd;
    logic [31:0]   sb;
    logic [2:0]    gw;
    logic signed [8:0] nc;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_flip};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_flip <= 1'b0;
        else if (psel && penable && pwrite && paddr == 1'b0) r_flip <= pwdata[0];
    end

    lmtf_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[2:0]), .i_column(s_axis_tdata[10:3]),
        .i_end_column(s_axis_tdata[18:11]), .i_pixel_row(s_axis_tdata[21:19]),
        .i_value(s_axis_tdata[29:22]), .i_char_code(s_axis_tdata[37:30]),
        .i_spacing(s_axis_tdata[41:38]),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_op(q_op)
    );

    lmtf_back u_back (
        .i_clk, .i_rst_n, .i_flip(r_flip),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_op(q_op),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_row_drive(rd), .o_shift_bits(sb), .o_glyph_width(gw),
        .o_next_column(nc), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, nc, gw, sb, rd};
endmodule

### hw/rtl/lmtf_front.sv
// Decodes one command into a t_op; glyph width lookup and range clamping here.
module lmtf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_cmd,
    input  logic signed [7:0]    i_column,
    input  logic signed [7:0]    i_end_column,
    input  logic [2:0]           i_pixel_row,
    input  logic [7:0]           i_value,
    input  logic [7:0]           i_char_code,
    input  logic [3:0]           i_spacing,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output lmtf_pkg::t_op        o_q_op
);
    // two-entry queue
    lmtf_pkg::t_op r_q [2];
    logic [1:0]    r_cnt;
    logic          r_wp, r_rp;
    lmtf_pkg::t_op n_op;
    logic          n_keep;
    logic [7:0]    code;
    logic [42:0]   fe;
    logic signed [9:0] col10, w10, sp10, end10;
    logic          push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_op    = r_q[r_rp];

    always_comb begin
        code  = (i_char_code < lmtf_pkg::FirstCode || i_char_code > lmtf_pkg::LastCode)
              ? lmtf_pkg::FallbackCode : i_char_code;
        fe    = lmtf_pkg::font_entry(7'(code - lmtf_pkg::FirstCode));
        col10 = 10'(i_column);
        w10   = {7'd0, fe[42:40]};
        sp10  = {6'd0, i_spacing};
        end10 = 10'(i_end_column);
        n_op  = '0;
        n_keep = 1'b1;
        n_op.pixel_row = i_pixel_row;
        n_op.value     = i_value;
        n_op.font_idx  = 7'(code - lmtf_pkg::FirstCode);
        n_op.width     = fe[42:40];
        n_op.next_col  = 9'(col10 + w10 + sp10);
        n_op.start     = col10;
        n_op.glyph_end = col10;
        n_op.stop      = col10 + 10'sd1;
        case (i_cmd)
            lmtf_pkg::CMD_WR_COL: begin
                n_op.is_walk   = 1'b1;
                n_op.glyph_end = col10 + 10'sd1;   // value used as the "glyph"
            end
            lmtf_pkg::CMD_WR_PIX: begin
                n_op.is_walk  = 1'b1;
                n_op.is_pixel = 1'b1;
            end
            lmtf_pkg::CMD_CLEAR: begin
                n_op.is_walk = 1'b1;
                n_op.stop    = end10;
            end
            lmtf_pkg::CMD_CHAR: begin
                n_op.is_walk   = 1'b1;
                n_op.is_char   = 1'b1;
                n_op.glyph_end = col10 + w10;
                n_op.stop      = col10 + w10 + sp10;
            end
            lmtf_pkg::CMD_REFRESH: n_op.is_refresh = 1'b1;
            default: n_keep = 1'b0;
        endcase
        // clamp walk to the display
        if (n_op.start < 10'sd0) n_op.start = 10'sd0;
        if (n_op.stop > 10'(lmtf_pkg::NCols)) n_op.stop = 10'(lmtf_pkg::NCols);
    end

    assign push = i_valid && o_ready && n_keep;
    assign pop  = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
        if (push) r_q[r_wp] <= n_op;
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !push) else $error("queue overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("bad count");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("ptr mismatch");
`endif
endmodule

### hw/rtl/lmtf_back.sv
// Executes queued ops on the 32-byte buffer: one column per cycle, one row per refresh result.
module lmtf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_flip,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  lmtf_pkg::t_op        i_q_op,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_row_drive,
    output logic [31:0]          o_shift_bits,
    output logic [2:0]           o_glyph_width,
    output logic signed [8:0]    o_next_column,
    output logic                 o_last
);
    logic [7:0]        r_fb [lmtf_pkg::NCols];
    lmtf_pkg::t_state  r_state, n_state;
    lmtf_pkg::t_op     r_op;
    logic signed [9:0] r_col, n_col;
    logic [2:0]        r_row;
    logic              r_ov, n_ov;
    logic [7:0]        r_rd;
    logic [31:0]       r_sb;
    logic [2:0]        r_gw;
    logic signed [8:0] r_nc;
    logic              r_lst;
    logic              out_free, wr_en, emit, take;
    logic [4:0]        lc, pc, wr_idx;
    logic [7:0]        wr_data, glyph_b, old_b;
    logic [2:0]        gi;
    logic [42:0]       fe;
    logic [31:0]       bits;

    assign out_free = !r_ov || i_ready;
    assign o_valid  = r_ov;
    assign o_row_drive = r_rd;
    assign o_shift_bits = r_sb;
    assign o_glyph_width = r_gw;
    assign o_next_column = r_nc;
    assign o_last = r_lst;

    always_comb begin
        lc = r_col[4:0];
        if (i_flip) lc = 5'(lmtf_pkg::NCols - 1) - lc;
        pc = {lc[4:3], lmtf_pkg::WirePerm[lc[2:0]]};
        wr_idx = pc;
        fe = lmtf_pkg::font_entry(r_op.font_idx);
        // glyph column counted from the unclamped start (glyph_end - width)
        gi = 3'(r_col - r_op.glyph_end + 10'(r_op.width));
        glyph_b = r_op.is_char ? fe[8*gi +: 8] : r_op.value;
        old_b = r_fb[pc];
        if (r_op.is_pixel) begin
            wr_data = old_b;
            wr_data[r_op.pixel_row] = r_op.value[0];
        end else if (r_col < r_op.glyph_end) begin
            wr_data = glyph_b;
        end else begin
            wr_data = 8'd0;
        end
        for (int k = 0; k < 8; k++)
            for (int j = 0; j < 4; j++)
                bits[4*k+j] = r_fb[(k + 24 - 8*j) % lmtf_pkg::NCols][r_row];
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        take    = 1'b0;
        case (r_state)
            lmtf_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    take = 1'b1;
                    n_col = i_q_op.start;
                    n_state = i_q_op.is_refresh ? lmtf_pkg::ST_ROWS : lmtf_pkg::ST_WALK;
                end
            end
            lmtf_pkg::ST_WALK: begin
                if (r_col < r_op.stop) n_col = r_col + 10'sd1;
                else if (!r_op.is_char || out_free) n_state = lmtf_pkg::ST_IDLE;
            end
            lmtf_pkg::ST_ROWS: begin
                if (out_free && r_row == 3'd7) n_state = lmtf_pkg::ST_IDLE;
            end
            default: n_state = lmtf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_ready = take;
        wr_en = (r_state == lmtf_pkg::ST_WALK) && (r_col < r_op.stop);
        emit  = 1'b0;
        case (r_state)
            lmtf_pkg::ST_WALK: emit = !(r_col < r_op.stop) && r_op.is_char && out_free;
            lmtf_pkg::ST_ROWS: emit = out_free;
            default: emit = 1'b0;
        endcase
        n_ov = emit ? 1'b1 : (r_ov && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmtf_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_row   <= '0;
            for (int i = 0; i < lmtf_pkg::NCols; i++) r_fb[i] <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (take) r_row <= '0;
            else if (r_state == lmtf_pkg::ST_ROWS && emit) r_row <= r_row + 3'd1;
            if (wr_en) r_fb[wr_idx] <= wr_data;
        end
        r_col <= n_col;
        if (take) r_op <= i_q_op;
        if (emit) begin
            r_lst <= (r_state == lmtf_pkg::ST_WALK) || (r_row == 3'd7);
            if (r_state == lmtf_pkg::ST_WALK) begin
                r_rd <= 8'hFF;
                r_sb <= '0;
                r_gw <= r_op.width;
                r_nc <= r_op.next_col;
            end else begin
                r_rd <= ~(8'd1 << lmtf_pkg::ScanRows[i_flip ? 3'd7 - r_row : r_row]);
                r_sb <= bits;
                r_gw <= '0;
                r_nc <= '0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> r_state == lmtf_pkg::ST_IDLE) else $error("take while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_sb)) else $error("result lost");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_col >= 10'sd0 && r_col < 10'(lmtf_pkg::NCols)) else $error("bad col");
`endif
endmodule
